[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// command codes, character codes, default geometry and bus widths
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // default screen geometry
    localparam int ROWS_DEF = 25;
    localparam int COLS_DEF = 80;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;

    // configuration
    localparam int         COLOR_W     = 8;
    localparam logic [7:0] COLOR_RESET = 8'h07;

    // character codes
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // request commands
    typedef enum logic [2:0] {
        CMD_PUT         = 3'd0,
        CMD_SCROLL_UP   = 3'd1,
        CMD_SCROLL_DOWN = 3'd2,
        CMD_CLEAR       = 3'd3,
        CMD_READ        = 3'd4
    } cmd_t;

endpackage

`default_nettype wire

[design/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer: text-mode screen store with cursor
// ROWS x COLS cells of character and color, put/scroll/clear/read requests
// ----------------------------------------------------------------------------
// usage
//   s_* stream: one request per handshake. s_tuser carries the command,
//   s_tdata the character, line count and the cell to read.
//   m_* stream: exactly one result per request, carrying the read cell
//   (zero unless a read) and the cursor after the request.
//   cfg_*: writes the color byte used for new and blank cells; always ready.
// steps per request (one memory with one write and one read port sets these)
//   put character or plain newline : decode and write, then result
//   read cell                      : decode, memory read, result
//   scroll up/down by n            : copy (ROWS-n)*COLS cells, then last write
//   clear n rows                   : fill n*COLS cells
//   newline or wrap at bottom row  : copy up, then blank row
// s_tready is high only while no request is in work; a finished result sits
// in the output register, so a new request can be taken while the receiver
// stalls, and its result waits in a hold state until the register frees up.
// reset clears the cursor to the top left corner and the color to 0x07; the
// screen memory itself is not cleared, cells read back only once written.
`default_nettype none

module text_console_writer #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // cmd[2:0]
    input  wire logic [tcw_pkg::S_TUSER_W-1:0] s_tuser,
    // character[7:0], line_count[13:8], cell_row[18:14], cell_col[25:19]
    input  wire logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    // result channel
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // read_char[7:0], read_color[15:8], cursor_row[20:16], cursor_col[27:21]
    output logic [tcw_pkg::M_TDATA_W-1:0]     m_tdata,
    // color register write
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [tcw_pkg::COLOR_W-1:0]  cfg_data
);
    import tcw_pkg::*;

    localparam int RC  = ROWS * COLS;
    localparam int AW  = $clog2(RC);       // cell address
    localparam int AW1 = $clog2(RC + 1);   // row base, may reach RC
    localparam int RW  = $clog2(ROWS);     // cursor row
    localparam int RW1 = $clog2(ROWS + 1); // row operand, may reach ROWS
    localparam int CW  = $clog2(COLS);     // cursor column

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COPY,
        ST_COPY_TAIL,
        ST_FILL,
        ST_READ,
        ST_HOLD
    } state_t;

    // screen memory: character in the low byte, color in the high byte
    logic [15:0]   mem [RC];
    logic [15:0]   rdata_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_wdata;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [7:0]       ch_reg, ch_next;
    logic [5:0]       lc_reg, lc_next;
    logic [4:0]       rrow_reg, rrow_next;
    logic [6:0]       rcol_reg, rcol_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [7:0]       color_reg, color_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [AW-1:0]    dst_reg, dst_next;
    logic [AW-1:0]    last_reg, last_next;
    logic             down_reg, down_next;
    logic             fill_after_reg, fill_after_next;
    logic             wr_pend_reg, wr_pend_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic [15:0]      res_reg, res_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // shared row-to-address unit
    logic [RW1-1:0] sel_row;
    logic [AW1-1:0] base;

    // line count decode
    logic       lc_neg;
    logic [6:0] lc_ext;
    logic [6:0] lc_abs;
    logic       scroll_ok;

    logic        out_free;
    logic        fin;
    logic [15:0] fin_data;
    logic        load;
    logic [15:0] load_data;
    logic        nl;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign lc_neg    = lc_reg[5];
    assign lc_ext    = {lc_reg[5], lc_reg};
    assign lc_abs    = lc_neg ? (7'd0 - lc_ext) : lc_ext;
    assign scroll_ok = !lc_neg && (lc_abs != 7'd0) && (lc_abs < 7'(ROWS));

    assign base     = AW1'(sel_row) * AW1'(COLS);
    assign out_free = !m_tvalid_reg || m_tready;

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        ch_next         = ch_reg;
        lc_next         = lc_reg;
        rrow_next       = rrow_reg;
        rcol_next       = rcol_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        color_next      = cfg_valid ? cfg_data : color_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        last_next       = last_reg;
        down_next       = down_reg;
        fill_after_next = fill_after_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        res_next        = res_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = rdata_reg;
        mem_re    = 1'b0;
        mem_raddr = src_reg;

        sel_row   = RW1'(row_reg);
        fin       = 1'b0;
        fin_data  = '0;
        load      = 1'b0;
        load_data = res_reg;
        nl        = 1'b0;

        // result taken by the receiver
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = cmd_t'(s_tuser);
                    ch_next    = s_tdata[7:0];
                    lc_next    = s_tdata[13:8];
                    rrow_next  = s_tdata[18:14];
                    rcol_next  = s_tdata[25:19];
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                unique case (cmd_reg)
                    CMD_PUT:
                    begin
                        sel_row = RW1'(row_reg);
                        if (ch_reg == CHAR_NUL)
                        begin
                            fin = 1'b1;
                        end
                        else if (ch_reg == CHAR_NEWLINE)
                        begin
                            nl = 1'b1;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(base + AW1'(col_reg));
                            mem_wdata = {color_reg, ch_reg};
                            if (col_reg == CW'(COLS - 1))
                            begin
                                nl = 1'b1;  // wrap at end of row
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                fin      = 1'b1;
                            end
                        end
                    end

                    CMD_SCROLL_UP:
                    begin
                        sel_row = RW1'(lc_abs);
                        if (scroll_ok)
                        begin
                            src_next        = AW'(base);
                            dst_next        = '0;
                            last_next       = AW'(RC - 1);
                            down_next       = 1'b0;
                            fill_after_next = 1'b0;
                            wr_pend_next    = 1'b0;
                            state_next      = ST_COPY;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end

                    CMD_SCROLL_DOWN:
                    begin
                        sel_row = RW1'(lc_abs);
                        if (scroll_ok)
                        begin
                            src_next        = AW'(RC - 1) - AW'(base);
                            dst_next        = AW'(RC - 1);
                            last_next       = '0;
                            down_next       = 1'b1;
                            fill_after_next = 1'b0;
                            wr_pend_next    = 1'b0;
                            state_next      = ST_COPY;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end

                    CMD_CLEAR:
                    begin
                        if (lc_abs == 7'd0)
                        begin
                            fin = 1'b1;
                        end
                        else if (!lc_neg)
                        begin
                            // top rows, saturating at the whole screen
                            sel_row    = (lc_abs >= 7'(ROWS)) ? RW1'(ROWS) : RW1'(lc_abs);
                            src_next   = '0;
                            last_next  = AW'(base - AW1'(1));
                            state_next = ST_FILL;
                        end
                        else
                        begin
                            // bottom rows
                            sel_row    = (lc_abs >= 7'(ROWS)) ? '0
                                                              : RW1'(7'(ROWS) - lc_abs);
                            src_next   = AW'(base);
                            last_next  = AW'(RC - 1);
                            state_next = ST_FILL;
                        end
                    end

                    CMD_READ:
                    begin
                        sel_row = RW1'(rrow_reg);
                        if ((7'(rrow_reg) < 7'(ROWS)) && (8'(rcol_reg) < 8'(COLS)))
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(base + AW1'(rcol_reg));
                            state_next = ST_READ;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end

                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase

                if (nl)
                begin
                    col_next = '0;
                    if (row_reg == RW'(ROWS - 1))
                    begin
                        // bottom row: move everything up one row, then blank it
                        src_next        = AW'(COLS);
                        dst_next        = '0;
                        last_next       = AW'(RC - 1);
                        down_next       = 1'b0;
                        fill_after_next = 1'b1;
                        wr_pend_next    = 1'b0;
                        state_next      = ST_COPY;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        fin      = 1'b1;
                    end
                end
            end

            ST_COPY:
            begin
                // read one cell ahead, write the one read last cycle
                mem_re       = 1'b1;
                mem_raddr    = src_reg;
                mem_we       = wr_pend_reg;
                mem_waddr    = wr_addr_reg;
                mem_wdata    = rdata_reg;
                wr_pend_next = 1'b1;
                wr_addr_next = dst_reg;
                if (src_reg == last_reg)
                begin
                    state_next = ST_COPY_TAIL;
                end
                else if (down_reg)
                begin
                    src_next = src_reg - 1'b1;
                    dst_next = dst_reg - 1'b1;
                end
                else
                begin
                    src_next = src_reg + 1'b1;
                    dst_next = dst_reg + 1'b1;
                end
            end

            ST_COPY_TAIL:
            begin
                mem_we       = 1'b1;
                mem_waddr    = wr_addr_reg;
                mem_wdata    = rdata_reg;
                wr_pend_next = 1'b0;
                if (fill_after_reg)
                begin
                    src_next   = AW'((ROWS - 1) * COLS);
                    last_next  = AW'(RC - 1);
                    state_next = ST_FILL;
                end
                else
                begin
                    fin = 1'b1;
                end
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = src_reg;
                mem_wdata = {color_reg, CHAR_SPACE};
                if (src_reg == last_reg)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    src_next = src_reg + 1'b1;
                end
            end

            ST_READ:
            begin
                fin      = 1'b1;
                fin_data = rdata_reg;
            end

            ST_HOLD:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    load_data = res_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // work done: hand to the output register or park it
        if (fin)
        begin
            if (out_free)
            begin
                load      = 1'b1;
                load_data = fin_data;
            end
            else
            begin
                res_next   = fin_data;
                state_next = ST_HOLD;
            end
        end

        if (load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0, 7'(col_next), 5'(row_next), load_data};
            state_next    = ST_IDLE;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= CMD_PUT;
            ch_reg         <= '0;
            lc_reg         <= '0;
            rrow_reg       <= '0;
            rcol_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            color_reg      <= COLOR_RESET;
            src_reg        <= '0;
            dst_reg        <= '0;
            last_reg       <= '0;
            down_reg       <= 1'b0;
            fill_after_reg <= 1'b0;
            wr_pend_reg    <= 1'b0;
            wr_addr_reg    <= '0;
            res_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            ch_reg         <= ch_next;
            lc_reg         <= lc_next;
            rrow_reg       <= rrow_next;
            rcol_reg       <= rcol_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            color_reg      <= color_next;
            src_reg        <= src_next;
            dst_reg        <= dst_next;
            last_reg       <= last_next;
            down_reg       <= down_next;
            fill_after_reg <= fill_after_next;
            wr_pend_reg    <= wr_pend_next;
            wr_addr_reg    <= wr_addr_next;
            res_reg        <= res_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire

[design/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks of the text console writer
// handshake behavior and cursor range seen on the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [tcw_pkg::M_TDATA_W-1:0] m_tdata
);

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // stalled result holds
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // cursor stays on screen
    a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (8'(m_tdata[27:21]) < 8'(COLS)))
        else $error("cursor column off screen");

    a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (7'(m_tdata[20:16]) < 7'(ROWS)))
        else $error("cursor row off screen");

    // padding bits stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:28] == 4'b0))
        else $error("result padding not zero");

endmodule

bind text_console_writer tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
